// ===== hdl/prfm_pkg.sv =====
// Package for the pixel rotate forward mapper: sizes, register indexes and
// the structs passed between the front, the back and the top level.
// No dependencies.
`default_nettype none

package prfm_pkg;

    // Screen size and trig fixed-point format
    localparam int SCREEN_WIDTH       = 480;
    localparam int SCREEN_HEIGHT      = 240;
    localparam int TRIG_FRACTION_BITS = 14;

    // Field widths
    localparam int CNT_W   = 12;
    localparam int COORD_W = 16;
    localparam int TRIG_W  = 16;
    localparam int COLOR_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // Offset from pivot: 12-bit unsigned minus 16-bit signed
    localparam int OFS_W  = COORD_W + 1;
    localparam int PROD_W = OFS_W + TRIG_W;
    localparam int PIV_W  = COORD_W + TRIG_FRACTION_BITS;
    localparam int SUM_W  = ((PROD_W > PIV_W) ? PROD_W : PIV_W) + 2;
    localparam int ROT_W  = SUM_W - TRIG_FRACTION_BITS;

    // Queue between front and back
    localparam int MQ_DEPTH = 2;
    localparam int MQ_AW    = 1;
    localparam int MQ_CW    = 2;

    // Result queue; deep enough to cover the back pipeline
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;
    localparam int RES_W    = 4;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_COS_VALUE    = 3'd0,
        REG_SIN_VALUE    = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_PIVOT_X      = 3'd4,
        REG_PIVOT_Y      = 3'd5,
        REG_DRAW_X       = 3'd6,
        REG_DRAW_Y       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_value;
        logic signed [TRIG_W-1:0]  sin_value;
        logic        [CNT_W-1:0]   image_width;
        logic        [CNT_W-1:0]   image_height;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
        logic signed [COORD_W-1:0] draw_x;
        logic signed [COORD_W-1:0] draw_y;
    } t_cfg;

    // One classified pixel: offsets from the pivot plus color
    typedef struct packed {
        logic signed [OFS_W-1:0] x_ofs;
        logic signed [OFS_W-1:0] y_ofs;
        logic        [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic        [COLOR_W-1:0] out_color;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/pixel_rotate_forward_mapper.sv =====
// Top level of the pixel rotate forward mapper: configuration registers and
// the front and back parts. Depends on prfm_pkg, prfm_front, prfm_back.
//
// Usage:
//   Input side is a queue write port: an RGB565 pixel (raster order) with a
//   frame start flag is taken at a clock edge with push high and full low.
//   Result side is a queue read port: while empty is low the oldest result
//   (screen x, screen y, color) is on the outputs; pop high takes it.
//   Pixels whose rotated position is off screen produce no result.
//   Configuration: write enable, 3-bit register index, 16-bit data; the user
//   must write it only while the block is idle (the block does not enforce
//   this); a write takes effect at once. Throughput: one pixel per clock
//   sustained while pop keeps pace. A pixel waits in the front queue, then
//   passes a product stage and a sum stage into the result queue.
//   The 4-entry result queue bounds the back part: when pop stays low the
//   back stops issuing, the 2-entry front queue fills and full rises.
//   Reset (synchronous, active low) empties both queues, clears the raster
//   counters and loads cosine = 1.0 with all other registers zero.
`default_nettype none

module pixel_rotate_forward_mapper (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr,
    input  wire logic [prfm_pkg::IDX_W-1:0]      i_cfg_idx,
    input  wire logic [prfm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [prfm_pkg::COLOR_W-1:0]    i_pixel_color,
    input  wire logic                            i_frame_start,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic signed [prfm_pkg::COORD_W-1:0]  o_screen_x,
    output logic signed [prfm_pkg::COORD_W-1:0]  o_screen_y,
    output logic [prfm_pkg::COLOR_W-1:0]         o_out_color
);

    prfm_pkg::t_cfg    r_cfg;
    prfm_pkg::t_item   w_item;
    prfm_pkg::t_result w_result;
    logic              w_mq_valid, w_mq_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{cos_value: prfm_pkg::TRIG_W'(1 << prfm_pkg::TRIG_FRACTION_BITS),
                       default: '0};
        end else if (i_cfg_wr) begin
            case (prfm_pkg::t_reg_idx'(i_cfg_idx))
                prfm_pkg::REG_COS_VALUE:    r_cfg.cos_value    <= i_cfg_data;
                prfm_pkg::REG_SIN_VALUE:    r_cfg.sin_value    <= i_cfg_data;
                prfm_pkg::REG_IMAGE_WIDTH:
                    r_cfg.image_width  <= i_cfg_data[prfm_pkg::CNT_W-1:0];
                prfm_pkg::REG_IMAGE_HEIGHT:
                    r_cfg.image_height <= i_cfg_data[prfm_pkg::CNT_W-1:0];
                prfm_pkg::REG_PIVOT_X:      r_cfg.pivot_x      <= i_cfg_data;
                prfm_pkg::REG_PIVOT_Y:      r_cfg.pivot_y      <= i_cfg_data;
                prfm_pkg::REG_DRAW_X:       r_cfg.draw_x       <= i_cfg_data;
                prfm_pkg::REG_DRAW_Y:       r_cfg.draw_y       <= i_cfg_data;
                default:                    r_cfg              <= r_cfg;
            endcase
        end
    end

    // Front: counters and offsets
    prfm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .i_pixel_color (i_pixel_color),
        .i_frame_start (i_frame_start),
        .o_full        (full),
        .o_valid       (w_mq_valid),
        .o_item        (w_item),
        .i_take        (w_mq_take)
    );

    // Back: rotation and result queue
    prfm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_mq_valid),
        .i_item   (w_item),
        .o_take   (w_mq_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (w_result)
    );

    assign o_screen_x  = w_result.screen_x;
    assign o_screen_y  = w_result.screen_y;
    assign o_out_color = w_result.out_color;

endmodule

`default_nettype wire

// ===== hdl/prfm_front.sv =====
// Front part: raster counters, pivot offsets and a two-entry request queue
// toward the back part. Depends on prfm_pkg.
`default_nettype none

module prfm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire prfm_pkg::t_cfg i_cfg,
    input  wire logic           i_push,
    input  wire logic [prfm_pkg::COLOR_W-1:0] i_pixel_color,
    input  wire logic           i_frame_start,
    output logic                o_full,
    output logic                o_valid,
    output prfm_pkg::t_item     o_item,
    input  wire logic           i_take
);

    logic [prfm_pkg::CNT_W-1:0] r_col, n_col;
    logic [prfm_pkg::CNT_W-1:0] r_row, n_row;
    logic [prfm_pkg::CNT_W-1:0] w_col_cur, w_row_cur;
    logic                       w_acc;
    prfm_pkg::t_item            w_item;

    prfm_pkg::t_item            r_q [prfm_pkg::MQ_DEPTH];
    logic [prfm_pkg::MQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [prfm_pkg::MQ_CW-1:0] r_count, n_count;

    assign w_acc = i_push && !o_full;

    // Position of this pixel; frame start restarts at the origin
    assign w_col_cur = i_frame_start ? '0 : r_col;
    assign w_row_cur = i_frame_start ? '0 : r_row;

    // Offsets from the pivot, exact in 17 bits
    always_comb begin
        w_item.x_ofs = $signed({{(prfm_pkg::OFS_W-prfm_pkg::CNT_W){1'b0}}, w_col_cur})
                     - $signed({i_cfg.pivot_x[prfm_pkg::COORD_W-1], i_cfg.pivot_x});
        w_item.y_ofs = $signed({{(prfm_pkg::OFS_W-prfm_pkg::CNT_W){1'b0}}, w_row_cur})
                     - $signed({i_cfg.pivot_y[prfm_pkg::COORD_W-1], i_cfg.pivot_y});
        w_item.color = i_pixel_color;
    end

    // Counter advance with wrap at width and height (zero acts like one)
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_acc) begin
            if ({1'b0, w_col_cur} + 1'b1 >= {1'b0, i_cfg.image_width}) begin
                n_col = '0;
                if ({1'b0, w_row_cur} + 1'b1 >= {1'b0, i_cfg.image_height}) begin
                    n_row = '0;
                end else begin
                    n_row = w_row_cur + 1'b1;
                end
            end else begin
                n_col = w_col_cur + 1'b1;
                n_row = w_row_cur;
            end
        end
    end

    // Queue occupancy
    always_comb begin
        n_count = r_count;
        case ({w_acc, i_take && o_valid})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_count <= n_count;
            if (w_acc) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_take && o_valid) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    assign o_full  = (r_count == prfm_pkg::MQ_CW'(prfm_pkg::MQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_q[r_rd_ptr];

    // Checks
    a_mq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= prfm_pkg::MQ_CW'(prfm_pkg::MQ_DEPTH))
        else $error("front queue overflow");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_frame_start && i_cfg.image_width > 12'd1) |=> (r_col == 12'd1))
        else $error("frame start did not restart the column counter");

endmodule

`default_nettype wire

// ===== hdl/prfm_back.sv =====
// Back part: rotation products, sums, truncation, screen test and the
// result queue. Depends on prfm_pkg.
`default_nettype none

module prfm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire prfm_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    input  wire prfm_pkg::t_item i_item,
    output logic                o_take,
    output logic                o_empty,
    input  wire logic           i_pop,
    output prfm_pkg::t_result   o_result
);

    // Stage 1: products
    logic                                r_v1;
    logic signed [prfm_pkg::PROD_W-1:0]  r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic        [prfm_pkg::COLOR_W-1:0] r_color1;

    // Stage 2: sums
    logic                                r_v2;
    logic signed [prfm_pkg::SUM_W-1:0]   r_num_x, r_num_y;
    logic        [prfm_pkg::COLOR_W-1:0] r_color2;
    logic signed [prfm_pkg::SUM_W-1:0]   n_num_x, n_num_y;
    logic signed [prfm_pkg::PIV_W-1:0]   w_piv_x, w_piv_y;

    // Stage 3: truncate, screen test
    logic signed [prfm_pkg::ROT_W-1:0]   w_rot_x, w_rot_y;
    logic                                w_on_screen;
    prfm_pkg::t_result                   w_res;

    // Result queue
    prfm_pkg::t_result                   r_oq [prfm_pkg::OQ_DEPTH];
    logic [prfm_pkg::OQ_AW-1:0]          r_wr_ptr, r_rd_ptr;
    logic [prfm_pkg::OQ_CW-1:0]          r_count, n_count;
    logic [prfm_pkg::RES_W-1:0]          w_reserved;
    logic                                w_wr, w_rd;

    // Truncation toward zero of num / 2^F
    function automatic logic signed [prfm_pkg::ROT_W-1:0] trunc_q(
        input logic signed [prfm_pkg::SUM_W-1:0] num
    );
        logic signed [prfm_pkg::ROT_W-1:0] q;
        q = num[prfm_pkg::SUM_W-1:prfm_pkg::TRIG_FRACTION_BITS];
        if (num[prfm_pkg::SUM_W-1] && (num[prfm_pkg::TRIG_FRACTION_BITS-1:0] != '0)) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    // Issue only when every request in flight has a result slot
    assign w_reserved = prfm_pkg::RES_W'(r_count) + prfm_pkg::RES_W'(r_v1)
                      + prfm_pkg::RES_W'(r_v2);
    assign o_take     = i_valid && (w_reserved < prfm_pkg::RES_W'(prfm_pkg::OQ_DEPTH));

    // Products
    always_ff @(posedge i_clk) begin
        r_p_xc   <= i_item.x_ofs * i_cfg.cos_value;
        r_p_ys   <= i_item.y_ofs * i_cfg.sin_value;
        r_p_xs   <= i_item.x_ofs * i_cfg.sin_value;
        r_p_yc   <= i_item.y_ofs * i_cfg.cos_value;
        r_color1 <= i_item.color;
    end

    // Pivot scaled to the fixed-point grid, then the rotation sums
    assign w_piv_x = $signed({i_cfg.pivot_x, {prfm_pkg::TRIG_FRACTION_BITS{1'b0}}});
    assign w_piv_y = $signed({i_cfg.pivot_y, {prfm_pkg::TRIG_FRACTION_BITS{1'b0}}});

    always_comb begin
        n_num_x = prfm_pkg::SUM_W'(w_piv_x) + prfm_pkg::SUM_W'(r_p_xc)
                - prfm_pkg::SUM_W'(r_p_ys);
        n_num_y = prfm_pkg::SUM_W'(w_piv_y) + prfm_pkg::SUM_W'(r_p_xs)
                + prfm_pkg::SUM_W'(r_p_yc);
    end

    always_ff @(posedge i_clk) begin
        r_num_x  <= n_num_x;
        r_num_y  <= n_num_y;
        r_color2 <= r_color1;
    end

    // Truncate, screen test, add draw offset
    always_comb begin
        w_rot_x     = trunc_q(r_num_x);
        w_rot_y     = trunc_q(r_num_y);
        w_on_screen = !w_rot_x[prfm_pkg::ROT_W-1] && !w_rot_y[prfm_pkg::ROT_W-1]
                   && (w_rot_x < prfm_pkg::ROT_W'(prfm_pkg::SCREEN_WIDTH))
                   && (w_rot_y < prfm_pkg::ROT_W'(prfm_pkg::SCREEN_HEIGHT));
        w_res.screen_x  = i_cfg.draw_x + w_rot_x[prfm_pkg::COORD_W-1:0];
        w_res.screen_y  = i_cfg.draw_y + w_rot_y[prfm_pkg::COORD_W-1:0];
        w_res.out_color = r_color2;
    end

    assign w_wr = r_v2 && w_on_screen;
    assign w_rd = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_v1    <= o_take;
            r_v2    <= r_v1;
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_oq[r_wr_ptr] <= w_res;
        end
    end

    assign o_empty  = (r_count == '0);
    assign o_result = r_oq[r_rd_ptr];

    // Checks
    a_reserve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reserved <= prfm_pkg::RES_W'(prfm_pkg::OQ_DEPTH))
        else $error("back pipeline over-committed the result queue");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (r_count < prfm_pkg::OQ_CW'(prfm_pkg::OQ_DEPTH)) || w_rd)
        else $error("result written into a full queue");

    a_pipe_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> ##1 r_v2)
        else $error("issued request lost in the back pipeline");

endmodule

`default_nettype wire
